// ===== src/can_multiframe_packet_reassembler_macros.svh =====
// Assertion macros used by the checker of the CAN packet reassembler.
// No dependencies; include by bare file name inside a module body.
`ifndef CAN_MULTIFRAME_PACKET_REASSEMBLER_MACROS_SVH
`define CAN_MULTIFRAME_PACKET_REASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cmr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cmr assertion failed");

`endif

// ===== src/cmr_pkg.sv =====
// Package of the CAN multi-frame packet reassembler: field layout, status codes,
// byte-unit operations. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmr_pkg;

    localparam int PACKET_BYTES_DEF = 260;

    localparam int ID_W      = 29;
    localparam int NBYTES_W  = 4;
    localparam int DATA_W    = 64;
    localparam int NODE_W    = 5;
    localparam int DEST_LSB  = 16;
    localparam int SRC_LSB   = 22;
    localparam int CNT_W     = 9;

    localparam logic [7:0]          HEAD_MARK = 8'hAA;
    localparam logic [CNT_W-1:0]    LEN_EXTRA = 9'd5;
    localparam logic [NBYTES_W-1:0] MAX_BYTES = 4'd8;
    localparam logic [NBYTES_W-1:0] MIN_FIRST = 4'd3;

    // Input tdata: frame_id, frame_bytes, frame_payload, zero padded to bytes.
    localparam int IN_BITS     = ID_W + NBYTES_W + DATA_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_NB_LSB   = ID_W;
    localparam int IN_PAY_LSB  = ID_W + NBYTES_W;

    // Output tdata: dest_node, src_node, chunk_data, chunk_count, zero padded.
    localparam int OUT_BITS     = 2 * NODE_W + DATA_W + NBYTES_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;
    localparam int OUT_CNT_LSB  = 2 * NODE_W + DATA_W;

    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_CHUNK    = 3'd1,
        ST_HDR_ERR  = 3'd2,
        ST_SRC_ERR  = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_SUM_ERR  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BU_HOLD  = 2'd0,
        BU_CLEAR = 2'd1,
        BU_ADD   = 2'd2,
        BU_PACK  = 2'd3
    } bu_op_t;

endpackage

`default_nettype wire

// ===== src/can_multiframe_packet_reassembler.sv =====
// Top level of the CAN multi-frame packet reassembler: sequencer, frame
// registers and output register. Depends on cmr_pkg, cmr_ram and cmr_byte_unit.
//
// One input item is one extended CAN frame. A packet opens with a frame whose
// first byte is 0xAA; its third byte L sets the packet length to L + 5 bytes.
// Continuation frames must repeat the destination (identifier bits 20..16) and
// the source (bits 26..22). Frame bytes go into a packet RAM one byte per
// cycle; a header, destination or source error is decided at once. When a
// packet completes, the same RAM read port and one 8-bit adder walk the packet
// once for the checksum, then the port reads it again to build chunks of up to
// 8 bytes, and the input stays closed until the last chunk has been offered.
// The input is ready only while the sequencer is idle; the result sits in an
// output register, so a new frame can be taken while it waits. Every frame
// yields either one status item (pending, header or destination error, source
// error, overrun, checksum error) or the chunks of a good packet, and m_tlast
// marks the final item that a frame causes. The packet RAM needs no clearing:
// only bytes written for the current packet are ever read.
`timescale 1ns / 1ps
`default_nettype none

module can_multiframe_packet_reassembler #(
    parameter int PACKET_BYTES = cmr_pkg::PACKET_BYTES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input frame channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata, low to high: frame_id[28:0], frame_bytes[32:29],
    // frame_payload[96:33], zero pad.
    input  wire logic [cmr_pkg::IN_TDATA_W-1:0] s_tdata,
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata, low to high: dest_node[4:0], src_node[9:5], chunk_data[73:10],
    // chunk_count[77:74], zero pad.
    output logic [cmr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: status[2:0].
    output cmr_pkg::status_t                    m_tuser,
    // m_tlast: last item caused by this frame.
    output logic                                m_tlast
);
    import cmr_pkg::*;

    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] PB_CNT = CNT_W'(PACKET_BYTES);

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_WRITE   = 8'b0000_0100,
        S_LEN     = 8'b0000_1000,
        S_SUM     = 8'b0001_0000,
        S_CHUNK   = 8'b0010_0000,
        S_CH_EMIT = 8'b0100_0000,
        S_ST_EMIT = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 receiving_reg, receiving_next;
    logic [NODE_W-1:0]    held_dest_reg, held_dest_next;
    logic [NODE_W-1:0]    held_src_reg, held_src_next;
    logic [CNT_W-1:0]     rcvd_reg, rcvd_next;
    logic [CNT_W-1:0]     need_reg, need_next;

    // Registered frame fields.
    logic [NODE_W-1:0]    fd_reg, fd_next;
    logic [NODE_W-1:0]    fs_reg, fs_next;
    logic [NBYTES_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0]    pay_reg, pay_next;
    status_t              stat_reg, stat_next;

    // Read walk over the packet RAM.
    logic [CNT_W-1:0]     ra_reg, ra_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 rd_end_reg, rd_end_next;
    logic                 rd_fin_reg, rd_fin_next;
    logic [2:0]           rd_low_reg, rd_low_next;

    // Output register.
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t                m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                 out_free;
    logic [NBYTES_W-1:0]  in_nbytes;
    logic [NBYTES_W-1:0]  in_nsat;
    logic                 hdr_bad;
    logic [CNT_W-1:0]     need_calc;
    logic [CNT_W-1:0]     need_m1;
    logic [CNT_W-1:0]     need_m2;
    logic                 issue;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    bu_op_t               bu_op;
    logic [7:0]           bu_acc;
    logic [63:0]          bu_chunk;
    logic [NBYTES_W-1:0]  emit_cnt;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_nbytes = s_tdata[IN_NB_LSB +: NBYTES_W];
    assign in_nsat   = (in_nbytes > MAX_BYTES) ? MAX_BYTES : in_nbytes;
    assign hdr_bad   = (rem_reg < MIN_FIRST) || (pay_reg[7:0] != HEAD_MARK);
    assign need_calc = {1'b0, pay_reg[23:16]} + LEN_EXTRA;
    assign need_m1   = need_reg - CNT_W'(1);
    assign need_m2   = need_reg - CNT_W'(2);
    assign issue     = (state_reg == S_SUM || state_reg == S_CHUNK) && !issue_done_reg;
    assign ram_we    = (state_reg == S_WRITE) && (rem_reg != '0) && (rcvd_reg < PB_CNT);
    assign emit_cnt  = NBYTES_W'({1'b0, rd_low_reg}) + NBYTES_W'(1);

    cmr_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (rcvd_reg[ADDR_W-1:0]),
        .wdata (pay_reg[7:0]),
        .raddr (ra_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    cmr_byte_unit u_bytes (
        .aclk  (aclk),
        .op    (bu_op),
        .idx   (rd_low_reg),
        .din   (ram_rdata),
        .acc   (bu_acc),
        .chunk (bu_chunk)
    );

    always_comb begin
        state_next      = state_reg;
        receiving_next  = receiving_reg;
        held_dest_next  = held_dest_reg;
        held_src_next   = held_src_reg;
        rcvd_next       = rcvd_reg;
        need_next       = need_reg;
        fd_next         = fd_reg;
        fs_next         = fs_reg;
        rem_next        = rem_reg;
        pay_next        = pay_reg;
        stat_next       = stat_reg;
        ra_next         = ra_reg;
        issue_done_next = issue_done_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        bu_op           = BU_HOLD;

        // Every read issued in the walk is tagged for the cycle its data returns.
        // The byte position and the final-byte flag hold until the next read.
        rd_vld_next = issue;
        rd_low_next = issue ? ra_reg[2:0] : rd_low_reg;
        rd_fin_next = issue ? (ra_reg == need_m1) : rd_fin_reg;
        rd_end_next = (state_reg == S_SUM) ? (ra_reg == need_m2)
                                           : ((ra_reg[2:0] == 3'd7) || (ra_reg == need_m1));
        if (issue) begin
            ra_next = ra_reg + CNT_W'(1);
            if (rd_end_next) begin
                issue_done_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    fd_next    = s_tdata[DEST_LSB +: NODE_W];
                    fs_next    = s_tdata[SRC_LSB +: NODE_W];
                    rem_next   = in_nsat;
                    pay_next   = s_tdata[IN_PAY_LSB +: DATA_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!receiving_reg) begin
                    need_next = need_calc;
                    if (hdr_bad) begin
                        stat_next  = ST_HDR_ERR;
                        state_next = S_ST_EMIT;
                    end else if (need_calc > PB_CNT) begin
                        stat_next  = ST_OVERRUN;
                        state_next = S_ST_EMIT;
                    end else begin
                        held_dest_next = fd_reg;
                        held_src_next  = fs_reg;
                        rcvd_next      = '0;
                        receiving_next = 1'b1;
                        state_next     = S_WRITE;
                    end
                end else if (fd_reg != held_dest_reg) begin
                    receiving_next = 1'b0;
                    stat_next      = ST_HDR_ERR;
                    state_next     = S_ST_EMIT;
                end else if (fs_reg != held_src_reg) begin
                    receiving_next = 1'b0;
                    stat_next      = ST_SRC_ERR;
                    state_next     = S_ST_EMIT;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (rem_reg != '0) begin
                    rcvd_next = rcvd_reg + CNT_W'(1);
                    pay_next  = pay_reg >> 8;
                    rem_next  = rem_reg - NBYTES_W'(1);
                end else begin
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                if (rcvd_reg > need_reg) begin
                    receiving_next = 1'b0;
                    stat_next      = ST_OVERRUN;
                    state_next     = S_ST_EMIT;
                end else if (rcvd_reg < need_reg) begin
                    stat_next  = ST_PENDING;
                    state_next = S_ST_EMIT;
                end else begin
                    // Checksum covers bytes 1 .. need-3 and is compared to need-2.
                    receiving_next  = 1'b0;
                    ra_next         = CNT_W'(1);
                    issue_done_next = 1'b0;
                    bu_op           = BU_CLEAR;
                    state_next      = S_SUM;
                end
            end
            S_SUM: begin
                if (rd_vld_reg) begin
                    if (rd_end_reg) begin
                        if (bu_acc == ram_rdata) begin
                            ra_next         = '0;
                            issue_done_next = 1'b0;
                            bu_op           = BU_CLEAR;
                            state_next      = S_CHUNK;
                        end else begin
                            stat_next  = ST_SUM_ERR;
                            state_next = S_ST_EMIT;
                        end
                    end else begin
                        bu_op = BU_ADD;
                    end
                end
            end
            S_CHUNK: begin
                if (rd_vld_reg) begin
                    bu_op = BU_PACK;
                    if (rd_end_reg) begin
                        state_next = S_CH_EMIT;
                    end
                end
            end
            S_CH_EMIT: begin
                // rd_low_reg and rd_fin_reg still describe the chunk's final byte.
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tuser_next    = ST_CHUNK;
                    m_tlast_next    = rd_fin_reg;
                    m_tdata_next    = {{OUT_PAD_W{1'b0}}, emit_cnt, bu_chunk,
                                       held_src_reg, held_dest_reg};
                    bu_op           = BU_CLEAR;
                    issue_done_next = 1'b0;
                    state_next      = rd_fin_reg ? S_IDLE : S_CHUNK;
                end
            end
            S_ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stat_reg;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, {NBYTES_W{1'b0}}, {DATA_W{1'b0}},
                                     fs_reg, fd_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            receiving_reg  <= 1'b0;
            held_dest_reg  <= '0;
            held_src_reg   <= '0;
            rcvd_reg       <= '0;
            need_reg       <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            receiving_reg  <= receiving_next;
            held_dest_reg  <= held_dest_next;
            held_src_reg   <= held_src_next;
            rcvd_reg       <= rcvd_next;
            need_reg       <= need_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fd_reg      <= fd_next;
        fs_reg      <= fs_next;
        rem_reg     <= rem_next;
        pay_reg     <= pay_next;
        stat_reg    <= stat_next;
        ra_reg      <= ra_next;
        rd_end_reg  <= rd_end_next;
        rd_fin_reg  <= rd_fin_next;
        rd_low_reg  <= rd_low_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== src/cmr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 260
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/cmr_byte_unit.sv =====
// Shared byte unit: 8-bit checksum accumulator and chunk packing register.
// Depends on cmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmr_byte_unit (
    input  wire logic            aclk,
    input  wire cmr_pkg::bu_op_t op,
    input  wire logic [2:0]      idx,
    input  wire logic [7:0]      din,
    output logic      [7:0]      acc,
    output logic      [63:0]     chunk
);
    import cmr_pkg::*;

    logic [7:0]  acc_reg, acc_next;
    logic [63:0] chunk_reg, chunk_next;

    always_comb begin
        acc_next   = acc_reg;
        chunk_next = chunk_reg;
        case (op)
            BU_CLEAR: begin
                acc_next   = 8'd0;
                chunk_next = 64'd0;
            end
            BU_ADD: begin
                acc_next = acc_reg + din;
            end
            BU_PACK: begin
                chunk_next[{idx, 3'b000} +: 8] = din;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        chunk_reg <= chunk_next;
    end

    assign acc   = acc_reg;
    assign chunk = chunk_reg;

endmodule

`default_nettype wire

// ===== src/cmr_checker.sv =====
// Port-level checker for the CAN packet reassembler, bound to the top level.
// Depends on cmr_pkg and can_multiframe_packet_reassembler_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module cmr_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [cmr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [2:0]                      m_tuser,
    input  wire logic                            m_tlast
);
    import cmr_pkg::*;
    `include "can_multiframe_packet_reassembler_macros.svh"

    logic [NBYTES_W-1:0] cnt;
    logic                is_chunk;

    assign cnt      = m_tdata[OUT_CNT_LSB +: NBYTES_W];
    assign is_chunk = (m_tuser == ST_CHUNK);

    // A waiting result stays offered.
    `CMR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // Status-only results carry no bytes and always close the frame's results.
    `CMR_ASSERT_SAME(a_status_only, aclk, aresetn, m_tvalid && !is_chunk, m_tlast && cnt == '0)
    // Chunks carry one to eight bytes.
    `CMR_ASSERT_SAME(a_chunk_cnt, aclk, aresetn, m_tvalid && is_chunk,
                     cnt != '0 && cnt <= MAX_BYTES)
    // The input is not ready in the cycle after a frame is accepted.
    `CMR_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind can_multiframe_packet_reassembler cmr_checker u_cmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_can_multiframe_packet_reassembler.sv =====
// Self-checking testbench of the CAN multi-frame packet reassembler.
// Depends on cmr_pkg and can_multiframe_packet_reassembler, and through it on cmr_ram and cmr_byte_unit.
`timescale 1ns / 1ps

module tb_can_multiframe_packet_reassembler;
    import cmr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int TARGET_FRAMES = 260;
    // The longest stretch with nothing accepted is the checksum walk of the
    // largest packet up to its first chunk, plus receiver stalls, so the
    // limit sits well above.
    localparam int QUIET_LIMIT   = 4000;
    // Settling time after the last expected item; covers one worst-case frame.
    localparam int DRAIN_CYCLES  = 600;

    // One input item: one extended CAN frame.
    typedef struct {
        logic [ID_W-1:0]     id;
        logic [NBYTES_W-1:0] nbytes;
        logic [DATA_W-1:0]   payload;
    } can_frame_t;

    // One result item as the block should deliver it.
    typedef struct {
        status_t             status;
        logic [NODE_W-1:0]   dest;
        logic [NODE_W-1:0]   src;
        logic [DATA_W-1:0]   data;
        logic [NBYTES_W-1:0] count;
        logic                is_last;
    } reassembly_result_t;

    // How a generated packet is spoiled, if at all.
    typedef enum {
        PKT_GOOD,
        PKT_BAD_SUM,
        PKT_OVERRUN,
        PKT_BAD_DEST,
        PKT_BAD_SRC,
        PKT_CUT
    } packet_fault_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    status_t                m_tuser;
    logic                   m_tlast;

    can_frame_t         frame_q[$];          // frames still to be sent
    reassembly_result_t expected_results[$]; // predicted items, oldest first

    int unsigned frames_taken = 0;
    int unsigned frames_total = 0;
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    logic        s_fire       = 1'b0;

    // Shadow state of the reassembler, updated once per accepted frame.
    logic              rx_active = 1'b0;
    logic [NODE_W-1:0] rx_dest   = '0;
    logic [NODE_W-1:0] rx_src    = '0;
    int unsigned       rx_have   = 0;
    int unsigned       rx_need   = 0;
    logic [7:0]        rx_store [PACKET_BYTES_DEF];

    // Idle percentages per phase: none, sender idle, receiver stalling, both.
    int unsigned send_idle_pct [4] = '{0, 64, 0, 24};
    int unsigned recv_idle_pct [4] = '{0, 0, 64, 24};

    can_multiframe_packet_reassembler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Status-only items carry the frame's own node fields and no data.
    function automatic void post_status(status_t st, logic [NODE_W-1:0] d,
                                        logic [NODE_W-1:0] s);
        reassembly_result_t r;
        r.status  = st;
        r.dest    = d;
        r.src     = s;
        r.data    = '0;
        r.count   = '0;
        r.is_last = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Works out every item that one accepted frame causes and queues them.
    function automatic void reassemble_frame(can_frame_t f);
        logic [NODE_W-1:0]  fd;
        logic [NODE_W-1:0]  fs;
        int unsigned        n;
        int unsigned        sum;
        int unsigned        cnt;
        reassembly_result_t r;
        fd = f.id[DEST_LSB +: NODE_W];
        fs = f.id[SRC_LSB +: NODE_W];
        // Byte counts above eight are treated as eight.
        n = (f.nbytes > MAX_BYTES) ? MAX_BYTES : f.nbytes;

        if (!rx_active) begin
            // An idle block only accepts a header frame of three bytes or more.
            if (n < MIN_FIRST || f.payload[7:0] != HEAD_MARK) begin
                post_status(ST_HDR_ERR, fd, fs);
                return;
            end
            rx_need = f.payload[23:16] + LEN_EXTRA;
            if (rx_need > PACKET_BYTES_DEF) begin
                post_status(ST_OVERRUN, fd, fs);
                return;
            end
            rx_dest   = fd;
            rx_src    = fs;
            rx_have   = 0;
            rx_active = 1'b1;
        end else if (fd != rx_dest) begin
            // The destination is checked before the source.
            rx_active = 1'b0;
            post_status(ST_HDR_ERR, fd, fs);
            return;
        end else if (fs != rx_src) begin
            rx_active = 1'b0;
            post_status(ST_SRC_ERR, fd, fs);
            return;
        end

        for (int unsigned i = 0; i < n; i++) begin
            if (rx_have + i < PACKET_BYTES_DEF) begin
                rx_store[rx_have + i] = f.payload[8*i +: 8];
            end
        end
        rx_have += n;

        if (rx_have > rx_need) begin
            rx_active = 1'b0;
            post_status(ST_OVERRUN, fd, fs);
            return;
        end
        if (rx_have < rx_need) begin
            post_status(ST_PENDING, fd, fs);
            return;
        end

        // Packet complete: byte need-2 must be the 8-bit sum of bytes 1..need-3.
        rx_active = 1'b0;
        sum = 0;
        for (int unsigned i = 1; i + 2 < rx_need; i++) begin
            sum = (sum + rx_store[i]) & 8'hFF;
        end
        if (sum != rx_store[rx_need - 2]) begin
            post_status(ST_SUM_ERR, fd, fs);
            return;
        end

        for (int unsigned base = 0; base < rx_need; base += 8) begin
            cnt       = (rx_need - base > 8) ? 8 : rx_need - base;
            r.status  = ST_CHUNK;
            r.dest    = rx_dest;
            r.src     = rx_src;
            r.data    = '0;
            r.count   = NBYTES_W'(cnt);
            r.is_last = (base + 8 >= rx_need);
            for (int unsigned j = 0; j < cnt; j++) begin
                r.data[8*j +: 8] = rx_store[base + j];
            end
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random identifier that carries the given destination and source.
    function automatic logic [ID_W-1:0] make_id(logic [NODE_W-1:0] d,
                                                logic [NODE_W-1:0] s);
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        id[DEST_LSB +: NODE_W] = d;
        id[SRC_LSB +: NODE_W]  = s;
        return id;
    endfunction

    function automatic void add_frame(logic [ID_W-1:0] id, logic [NBYTES_W-1:0] nb,
                                      logic [DATA_W-1:0] pay);
        can_frame_t f;
        f.id      = id;
        f.nbytes  = nb;
        f.payload = pay;
        frame_q.push_back(f);
    endfunction

    // Builds a packet with third byte len_byte and a correct sum, spoils it
    // as asked, and splits it into frames of random sizes.
    function automatic void queue_packet(int unsigned len_byte, logic [NODE_W-1:0] d,
                                         logic [NODE_W-1:0] s, packet_fault_t fault);
        byte unsigned        pkt[$];
        int unsigned         need;
        int unsigned         pos;
        int unsigned         n;
        int unsigned         sum;
        int unsigned         cut_at;
        logic [DATA_W-1:0]   pay;
        logic [NBYTES_W-1:0] nb;
        logic [NODE_W-1:0]   fd;
        logic [NODE_W-1:0]   fs;
        bit                  spoiled;
        need = len_byte + LEN_EXTRA;
        for (int unsigned i = 0; i < need; i++) begin
            pkt.push_back(8'($urandom));
        end
        pkt[0] = HEAD_MARK;
        pkt[2] = 8'(len_byte);
        sum = 0;
        for (int unsigned i = 1; i + 2 < need; i++) begin
            sum += pkt[i];
        end
        pkt[need - 2] = 8'(sum);
        if (fault == PKT_BAD_SUM) begin
            pkt[need - 2] ^= 8'(1 << $urandom_range(7));
        end
        // Surplus bytes past the end of the packet for an overrun.
        if (fault == PKT_OVERRUN) begin
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
        cut_at = (fault == PKT_CUT) ? $urandom_range(3, need - 1) : need + 8;

        pos = 0;
        while (pos < pkt.size()) begin
            if (pos >= cut_at) begin
                break;
            end
            if (pos == 0) begin
                n = $urandom_range(3, 8);
            end else begin
                // Now and then an empty continuation frame.
                n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (n > pkt.size() - pos) begin
                n = pkt.size() - pos;
            end
            // An overrun packet must never land exactly on its length.
            if (fault == PKT_OVERRUN && pos + n == need) begin
                n = (n < 8) ? n + 1 : n - 1;
            end
            fd = d;
            fs = s;
            spoiled = 1'b0;
            if (pos != 0 && (fault == PKT_BAD_DEST || fault == PKT_BAD_SRC)
                    && $urandom_range(2) == 0) begin
                if (fault == PKT_BAD_DEST) begin
                    fd = d ^ NODE_W'($urandom_range(1, 31));
                    // Sometimes the source is wrong too; the destination wins.
                    if ($urandom_range(1) == 1) begin
                        fs = s ^ NODE_W'($urandom_range(1, 31));
                    end
                end else begin
                    fs = s ^ NODE_W'($urandom_range(1, 31));
                end
                spoiled = 1'b1;
            end
            pay = rand_word();
            for (int unsigned i = 0; i < n; i++) begin
                pay[8*i +: 8] = pkt[pos + i];
            end
            // Full frames sometimes carry a byte count above eight.
            nb = (n == 8 && $urandom_range(1) == 1) ? NBYTES_W'($urandom_range(8, 15))
                                                    : NBYTES_W'(n);
            add_frame(make_id(fd, fs), nb, pay);
            pos += n;
            if (spoiled) begin
                break;
            end
        end
    endfunction

    function automatic int unsigned run_phase();
        int unsigned p;
        p = frames_taken * 4 / frames_total;
        return (p > 3) ? 3 : p;
    endfunction

    // ------------------------------------------------------------------
    // Sender: presents frame_q[0] and holds it until it is taken.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // Item still waiting for s_tready; keep it unchanged.
        end else if (frame_q.size() != 0
                     && $urandom_range(99) >= send_idle_pct[run_phase()]) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, frame_q[0].payload,
                         frame_q[0].nbytes, frame_q[0].id};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: back-pressure according to the current phase.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct[run_phase()]);
        end
    end

    // ------------------------------------------------------------------
    // Checking and prediction at the rising edge. Results are checked
    // before the frame accepted at the same edge is predicted.
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : edge_work
        reassembly_result_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: status %0d, tdata 0x%0h", m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("dest_node", want.dest, m_tdata[0 +: NODE_W]);
                check_field("src_node", want.src, m_tdata[NODE_W +: NODE_W]);
                check_field("chunk_data", want.data, m_tdata[2*NODE_W +: DATA_W]);
                check_field("chunk_count", want.count, m_tdata[OUT_CNT_LSB +: NBYTES_W]);
                check_field("last", want.is_last, m_tlast);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            reassemble_frame(frame_q.pop_front());
            frames_taken <= frames_taken + 1;
        end
    end

    // Watchdog: ends a run in which no item moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned pick;
        int unsigned len_byte;
        packet_fault_t fault;

        // Directed part. Field extremes: all-zero frame, all-ones short
        // frame with a good header byte, saturated count with a bad header.
        add_frame('0, '0, '0);
        add_frame({ID_W{1'b1}}, 4'd2, {{56{1'b1}}, HEAD_MARK});
        add_frame({ID_W{1'b1}}, 4'd15, {DATA_W{1'b1}});
        add_frame(make_id(5'd3, 5'd7), 4'd8, DATA_W'({rand_word() >> 8, 8'h55}));
        // Smallest packet, good and with a broken sum.
        queue_packet(0, 5'd31, 5'd0, PKT_GOOD);
        queue_packet(0, 5'd0, 5'd31, PKT_BAD_SUM);
        // Header frame that already overruns: length five, eight bytes sent.
        add_frame(make_id(5'd9, 5'd9), 4'd15,
                  DATA_W'({rand_word() >> 24, 8'h00, 8'h12, HEAD_MARK}));
        // Three-byte header, an empty continuation that stays pending, then a
        // frame with both nodes wrong: the destination error must win.
        add_frame(make_id(5'd3, 5'd4), 4'd3,
                  DATA_W'({rand_word() >> 24, 8'd30, 8'h01, HEAD_MARK}));
        add_frame(make_id(5'd3, 5'd4), 4'd0, rand_word());
        add_frame(make_id(5'd4, 5'd5), 4'd8, rand_word());
        // Same destination, wrong source.
        add_frame(make_id(5'd3, 5'd4), 4'd8,
                  DATA_W'({rand_word() >> 24, 8'd30, 8'h01, HEAD_MARK}));
        add_frame(make_id(5'd3, 5'd5), 4'd8, rand_word());
        // A multi-frame good packet and an overrun in a continuation frame.
        queue_packet(20, 5'd5, 5'd9, PKT_GOOD);
        queue_packet(10, 5'd17, 5'd2, PKT_OVERRUN);

        // Random part. The largest packet comes first; after that most
        // packets are short, with faults and noise mixed in.
        queue_packet(255, NODE_W'($urandom), NODE_W'($urandom), PKT_GOOD);
        while (frame_q.size() < TARGET_FRAMES) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                add_frame(ID_W'($urandom), NBYTES_W'($urandom), rand_word());
            end else if (pick < 10) begin
                add_frame(ID_W'($urandom), NBYTES_W'($urandom_range(2)),
                          DATA_W'({rand_word() >> 8, HEAD_MARK}));
            end else begin
                len_byte = ($urandom_range(15) == 0) ? $urandom_range(60, 255)
                                                     : $urandom_range(0, 30);
                pick = $urandom_range(99);
                if (pick < 50) begin
                    fault = PKT_GOOD;
                end else if (pick < 60) begin
                    fault = PKT_BAD_SUM;
                end else if (pick < 70) begin
                    fault = PKT_OVERRUN;
                end else if (pick < 80) begin
                    fault = PKT_BAD_DEST;
                end else if (pick < 90) begin
                    fault = PKT_BAD_SRC;
                end else begin
                    fault = PKT_CUT;
                end
                queue_packet(len_byte, NODE_W'($urandom), NODE_W'($urandom), fault);
            end
        end
        frames_total = frame_q.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sampled at the falling edge so the rising-edge updates have settled.
        while (frame_q.size() != 0 || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
